// ----- rtl/core/hsfr_pkg.sv -----
// Shared types and constants for the handshake frame receiver.
// No dependencies; imported by every module of the block.
package hsfr_pkg;

    // Bits per character on the serial line
    localparam int unsigned BITS_PER_CHAR = 8;
    localparam int unsigned BIT_IDX_W     = $clog2(BITS_PER_CHAR);
    localparam logic [BIT_IDX_W-1:0] LAST_BIT = BIT_IDX_W'(BITS_PER_CHAR - 1);

    // Register reset values
    localparam logic [7:0] START_MARKER_RST = 8'd224;
    localparam logic [7:0] END_MARKER_RST   = 8'd234;

    // Register map: index taken from paddr[2]
    localparam int unsigned PADDR_W = 3;
    localparam logic REG_START_MARKER = 1'b0;
    localparam logic REG_END_MARKER   = 1'b1;

    // Marker configuration
    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] end_marker;
    } cfg_t;

    // One result beat
    typedef struct packed {
        logic       ack_level;
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       frame_end;
    } beat_t;

endpackage

// ----- rtl/core/hsfr_cfg.sv -----
// APB register block holding the start and end marker bytes.
// Depends on hsfr_pkg.
module hsfr_cfg
    import hsfr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t cfg_reg;
    logic wr_en;
    logic reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_marker <= START_MARKER_RST;
            cfg_reg.end_marker   <= END_MARKER_RST;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_START_MARKER: cfg_reg.start_marker <= pwdata[7:0];
                REG_END_MARKER:   cfg_reg.end_marker   <= pwdata[7:0];
                default:          ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (reg_sel)
            REG_START_MARKER: prdata = {24'd0, cfg_reg.start_marker};
            REG_END_MARKER:   prdata = {24'd0, cfg_reg.end_marker};
            default:          prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/core/hsfr_deframe.sv -----
// Handshake bit capture, byte assembly and marker deframing for one sample.
// Depends on hsfr_pkg.
module hsfr_deframe
    import hsfr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  advance,
    input  logic  strobe_level,
    input  logic  data_bit,
    input  cfg_t  cfg,
    output beat_t res
);

    logic                 awaiting_release_reg, awaiting_release_next;
    logic [BIT_IDX_W-1:0] bit_index_reg, bit_index_next;
    logic [7:0]           shift_bits_reg, shift_bits_next;
    logic                 in_frame_reg, in_frame_next;

    // Next state and result for the current sample
    always_comb
    begin
        awaiting_release_next = awaiting_release_reg;
        bit_index_next        = bit_index_reg;
        shift_bits_next       = shift_bits_reg;
        in_frame_next         = in_frame_reg;
        res                   = '0;

        if (!awaiting_release_reg)
        begin
            // capture on strobe high
            if (strobe_level)
            begin
                shift_bits_next[bit_index_reg] = data_bit;
                awaiting_release_next          = 1'b1;
                res.ack_level                  = 1'b1;
            end
        end
        else if (strobe_level)
        begin
            res.ack_level = 1'b1;
        end
        else
        begin
            // release: count the bit, deframe a completed byte
            awaiting_release_next = 1'b0;
            if (bit_index_reg == LAST_BIT)
            begin
                bit_index_next  = '0;
                shift_bits_next = '0;
                if (shift_bits_reg == cfg.start_marker)
                begin
                    in_frame_next = 1'b1;
                end
                else if (shift_bits_reg == cfg.end_marker)
                begin
                    in_frame_next = 1'b0;
                    res.frame_end = 1'b1;
                end
                else if (in_frame_reg)
                begin
                    res.payload_valid = 1'b1;
                    res.payload_byte  = shift_bits_reg;
                end
            end
            else
            begin
                bit_index_next = bit_index_reg + 1'b1;
            end
        end
    end

    // State update on each accepted sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_release_reg <= 1'b0;
            bit_index_reg        <= '0;
            shift_bits_reg       <= '0;
            in_frame_reg         <= 1'b0;
        end
        else if (advance)
        begin
            awaiting_release_reg <= awaiting_release_next;
            bit_index_reg        <= bit_index_next;
            shift_bits_reg       <= shift_bits_next;
            in_frame_reg         <= in_frame_next;
        end
    end

endmodule

// ----- rtl/core/hsfr_outbuf.sv -----
// Output register with a skid stage for result beats.
// Depends on hsfr_pkg.
module hsfr_outbuf
    import hsfr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  beat_t push_beat,
    output logic  full,
    output logic  out_valid,
    input  logic  out_stall,
    output beat_t out_beat
);

    logic  main_valid_reg;
    beat_t main_beat_reg;
    logic  skid_valid_reg;
    beat_t skid_beat_reg;
    logic  take;

    assign take = main_valid_reg && !out_stall;

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (take || !main_valid_reg)
        begin
            main_beat_reg <= skid_valid_reg ? skid_beat_reg : push_beat;
        end
        else if (push)
        begin
            skid_beat_reg <= push_beat;
        end
    end

    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_beat  = main_beat_reg;

endmodule

// ----- rtl/core/handshake_frame_receiver.sv -----
// Top level of the handshake frame receiver: APB markers, deframer, output buffer.
// Depends on hsfr_pkg, hsfr_cfg, hsfr_deframe and hsfr_outbuf.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one pin sample per beat:
//   strobe_level and data_bit. Each accepted sample yields exactly one
//   result beat on the output channel (out_valid/out_stall): ack_level,
//   payload_valid, payload_byte and frame_end.
//   Each result is registered in the output register, or in the skid stage on a
//   stall. Throughput is one sample per cycle while in_stall is low; deframer
//   state and result logic sit between the input ports and the output register.
//   When the receiver stalls, one further result lands in the skid stage
//   and in_stall rises until the output drains; nothing is lost.
//   Reset clears the handshake state, the frame state and both buffer stages,
//   and loads the markers with 224 (start) and 234 (end). The user must write
//   markers over APB at byte addresses 0 and 4 only while idle (not enforced).
module handshake_frame_receiver
    import hsfr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               strobe_level,
    input  logic               data_bit,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               ack_level,
    output logic               payload_valid,
    output logic [7:0]         payload_byte,
    output logic               frame_end,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    cfg_t  cfg;
    beat_t res;
    beat_t out_beat;
    logic  buf_full;
    logic  accept;

    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;

    hsfr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hsfr_deframe u_deframe (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (accept),
        .strobe_level (strobe_level),
        .data_bit     (data_bit),
        .cfg          (cfg),
        .res          (res)
    );

    hsfr_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_beat (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_beat  (out_beat)
    );

    assign ack_level     = out_beat.ack_level;
    assign payload_valid = out_beat.payload_valid;
    assign payload_byte  = out_beat.payload_byte;
    assign frame_end     = out_beat.frame_end;

endmodule
